// File: rtl/core/bfsra_pkg.sv
`default_nettype none
package bfsra_pkg;

  localparam int DIM_W     = 13;
  localparam int AREA_W    = 2 * DIM_W;
  localparam int SLOT_IO_W = 8;
  localparam int GEN_IO_W  = 16;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_REL   = 2'd2,
    MODE_CHK   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_RD,
    ST_REL,
    ST_CHK,
    ST_SCAN,
    ST_AL_RD,
    ST_AL_MOVE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic clear;
    logic issue;
  } scan_ctl_t;

  typedef struct packed {
    logic busy;
    logic found;
  } scan_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/bfsra_ram.sv
`default_nettype none
module bfsra_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/bfsra_fit_unit.sv
`default_nettype none
module bfsra_fit_unit
  import bfsra_pkg::*;
#(
  parameter int IDX_W = 8,
  parameter int GEN_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire scan_ctl_t        ctl,
  input  wire logic [IDX_W-1:0] issue_pos,
  input  wire logic [IDX_W-1:0] fl_data,
  input  wire logic [DIM_W-1:0] ent_w,
  input  wire logic [DIM_W-1:0] ent_h,
  input  wire logic [GEN_W-1:0] ent_gen,
  input  wire logic [DIM_W-1:0] req_w,
  input  wire logic [DIM_W-1:0] req_h,
  output logic                  slot_re,
  output logic      [IDX_W-1:0] slot_raddr,
  output scan_sts_t             sts,
  output logic      [IDX_W-1:0] best_pos,
  output logic      [IDX_W-1:0] best_slot,
  output logic      [GEN_W-1:0] best_gen
);

  logic              s1_v_r, s2_v_r, s3_v_r;
  logic [IDX_W-1:0]  s1_pos_r, s2_pos_r, s3_pos_r;
  logic [IDX_W-1:0]  s2_slot_r, s3_slot_r;
  logic              s3_fit_r;
  logic [AREA_W-1:0] s3_area_r;
  logic [GEN_W-1:0]  s3_gen_r;
  logic              found_r;
  logic [AREA_W-1:0] best_area_r;
  logic [IDX_W-1:0]  best_pos_r, best_slot_r;
  logic [GEN_W-1:0]  best_gen_r;
  logic              take;

  assign slot_re    = s1_v_r;
  assign slot_raddr = fl_data;

  assign take = s3_v_r && s3_fit_r && (!found_r || (s3_area_r < best_area_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      s1_v_r <= ctl.issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      if (ctl.clear) begin
        found_r <= 1'b0;
      end else if (take) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_pos_r  <= issue_pos;
    s2_pos_r  <= s1_pos_r;
    s2_slot_r <= fl_data;
    s3_pos_r  <= s2_pos_r;
    s3_slot_r <= s2_slot_r;
    s3_gen_r  <= ent_gen;
    s3_fit_r  <= (req_w <= ent_w) && (req_h <= ent_h);
    s3_area_r <= AREA_W'(ent_w) * AREA_W'(ent_h);
    if (take) begin
      best_area_r <= s3_area_r;
      best_pos_r  <= s3_pos_r;
      best_slot_r <= s3_slot_r;
      best_gen_r  <= s3_gen_r;
    end
  end

  assign sts.busy  = s1_v_r || s2_v_r || s3_v_r;
  assign sts.found = found_r;
  assign best_pos  = best_pos_r;
  assign best_slot = best_slot_r;
  assign best_gen  = best_gen_r;

endmodule
`default_nettype wire

// File: rtl/core/best_fit_slot_reuse_allocator.sv
`default_nettype none
// Channel | Ports                                                    | Dir
// in      | in_valid in_stall in_mode in_req_width in_req_height     | in
//         | in_slot_index in_handle_generation                       |
// out     | out_valid out_stall out_ok out_result_slot               | out
//         | out_result_generation                                    |
// One request at a time; one result per request through an output register.
// Allocate streams the free list one entry a cycle through a shared fit/area
// multiplier stage.
// rst_n is synchronous; the slot table and free list need no clearing.
// in_stall is high while a request is in progress; a stalled result holds.
module best_fit_slot_reuse_allocator
  import bfsra_pkg::*;
#(
  parameter int SLOTS    = 256,
  parameter int MAX_DIM  = 4096,
  parameter int GEN_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_mode,
  input  wire logic [DIM_W-1:0]     in_req_width,
  input  wire logic [DIM_W-1:0]     in_req_height,
  input  wire logic [SLOT_IO_W-1:0] in_slot_index,
  input  wire logic [GEN_IO_W-1:0]  in_handle_generation,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_ok,
  output logic      [SLOT_IO_W-1:0] out_result_slot,
  output logic      [GEN_IO_W-1:0]  out_result_generation
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (CNT_W > SLOT_IO_W) ? CNT_W : SLOT_IO_W;
  localparam int GC_W  = (GEN_BITS > GEN_IO_W) ? GEN_BITS : GEN_IO_W;
  localparam int ENT_W = 2 * DIM_W + GEN_BITS + 1;

  state_t               state_r, state_nxt;
  mode_t                req_mode_r;
  logic [DIM_W-1:0]     req_w_r, req_h_r;
  logic [SLOT_IO_W-1:0] req_idx_r;
  logic [GEN_IO_W-1:0]  req_hgen_r;
  logic [CNT_W-1:0]     slot_count_r, slot_count_nxt;
  logic [CNT_W-1:0]     free_count_r, free_count_nxt;
  logic [CNT_W-1:0]     scan_i_r, scan_i_nxt;
  logic                 res_ok_r, res_ok_nxt;
  logic [IDX_W-1:0]     res_slot_r, res_slot_nxt;
  logic [GEN_BITS-1:0]  res_gen_r, res_gen_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ok_r;
  logic [SLOT_IO_W-1:0] out_slot_r;
  logic [GEN_IO_W-1:0]  out_gen_r;

  logic                 accept, dims_in, out_free, load_out;
  logic [CMP_W-1:0]     idx_wide;
  logic                 idx_known;
  logic [IDX_W-1:0]     idx_addr;

  logic                 sm_we, sm_re;
  logic [IDX_W-1:0]     sm_waddr, sm_raddr;
  logic [ENT_W-1:0]     sm_wdata, sm_rdata;
  logic [DIM_W-1:0]     ent_w, ent_h;
  logic [GEN_BITS-1:0]  ent_gen;
  logic                 ent_live;

  logic                 fl_we, fl_re;
  logic [IDX_W-1:0]     fl_waddr, fl_raddr, fl_wdata, fl_rdata;

  scan_ctl_t            scan_ctl;
  scan_sts_t            scan_sts;
  logic                 fit_re;
  logic [IDX_W-1:0]     fit_raddr, best_pos, best_slot;
  logic [GEN_BITS-1:0]  best_gen;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign dims_in  = (in_req_width != '0) && (in_req_height != '0) &&
                    (32'(in_req_width) <= 32'(MAX_DIM)) &&
                    (32'(in_req_height) <= 32'(MAX_DIM));
  assign out_free = !out_valid_r || !out_stall;

  assign idx_wide  = CMP_W'(req_idx_r);
  assign idx_known = idx_wide < CMP_W'(slot_count_r);
  assign idx_addr  = idx_wide[IDX_W-1:0];

  assign ent_w    = sm_rdata[ENT_W-1 -: DIM_W];
  assign ent_h    = sm_rdata[ENT_W-1-DIM_W -: DIM_W];
  assign ent_gen  = sm_rdata[GEN_BITS:1];
  assign ent_live = sm_rdata[0];

  bfsra_ram #(.W(ENT_W), .DEPTH(SLOTS), .AW(IDX_W)) u_slot_ram (
    .clk   (clk),
    .we    (sm_we),
    .waddr (sm_waddr),
    .wdata (sm_wdata),
    .re    (sm_re),
    .raddr (sm_raddr),
    .rdata (sm_rdata)
  );

  bfsra_ram #(.W(IDX_W), .DEPTH(SLOTS), .AW(IDX_W)) u_free_ram (
    .clk   (clk),
    .we    (fl_we),
    .waddr (fl_waddr),
    .wdata (fl_wdata),
    .re    (fl_re),
    .raddr (fl_raddr),
    .rdata (fl_rdata)
  );

  bfsra_fit_unit #(.IDX_W(IDX_W), .GEN_W(GEN_BITS)) u_fit (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .issue_pos  (scan_i_r[IDX_W-1:0]),
    .fl_data    (fl_rdata),
    .ent_w      (ent_w),
    .ent_h      (ent_h),
    .ent_gen    (ent_gen),
    .req_w      (req_w_r),
    .req_h      (req_h_r),
    .slot_re    (fit_re),
    .slot_raddr (fit_raddr),
    .sts        (scan_sts),
    .best_pos   (best_pos),
    .best_slot  (best_slot),
    .best_gen   (best_gen)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_count_r <= '0;
      free_count_r <= '0;
      scan_i_r     <= '0;
      out_valid_r  <= 1'b0;
      res_ok_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_count_r <= slot_count_nxt;
      free_count_r <= free_count_nxt;
      scan_i_r     <= scan_i_nxt;
      out_valid_r  <= out_valid_nxt;
      res_ok_r     <= res_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_slot_r <= res_slot_nxt;
    res_gen_r  <= res_gen_nxt;
    if (accept) begin
      req_mode_r <= mode_t'(in_mode);
      req_w_r    <= in_req_width;
      req_h_r    <= in_req_height;
      req_idx_r  <= in_slot_index;
      req_hgen_r <= in_handle_generation;
    end
    if (load_out) begin
      out_ok_r   <= res_ok_r;
      out_slot_r <= SLOT_IO_W'(CMP_W'(res_slot_r));
      out_gen_r  <= GEN_IO_W'(GC_W'(res_gen_r));
    end
  end

  always_comb begin
    state_nxt      = state_r;
    slot_count_nxt = slot_count_r;
    free_count_nxt = free_count_r;
    scan_i_nxt     = scan_i_r;
    res_ok_nxt     = res_ok_r;
    res_slot_nxt   = res_slot_r;
    res_gen_nxt    = res_gen_r;
    out_valid_nxt  = out_valid_r && out_stall;
    load_out       = 1'b0;
    scan_ctl.clear = 1'b0;
    scan_ctl.issue = 1'b0;
    sm_we          = 1'b0;
    sm_waddr       = idx_addr;
    sm_wdata       = {ent_w, ent_h, ent_gen, 1'b0};
    sm_re          = fit_re;
    sm_raddr       = fit_raddr;
    fl_we          = 1'b0;
    fl_waddr       = free_count_r[IDX_W-1:0];
    fl_wdata       = idx_addr;
    fl_re          = 1'b0;
    fl_raddr       = scan_i_r[IDX_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_ok_nxt     = 1'b0;
          res_slot_nxt   = '0;
          res_gen_nxt    = '0;
          scan_i_nxt     = '0;
          scan_ctl.clear = 1'b1;
          unique case (mode_t'(in_mode))
            MODE_ALLOC: state_nxt = dims_in ? ST_SCAN : ST_RESP;
            MODE_ADD: begin
              state_nxt = (dims_in && (slot_count_r < CNT_W'(SLOTS))) ? ST_ADD : ST_RESP;
            end
            MODE_REL,
            MODE_CHK:   state_nxt = ST_RD;
          endcase
        end
      end
      ST_ADD: begin
        sm_we          = 1'b1;
        sm_waddr       = slot_count_r[IDX_W-1:0];
        sm_wdata       = {req_w_r, req_h_r, {GEN_BITS{1'b0}}, 1'b1};
        slot_count_nxt = slot_count_r + 1'b1;
        res_ok_nxt     = 1'b1;
        res_slot_nxt   = slot_count_r[IDX_W-1:0];
        state_nxt      = ST_RESP;
      end
      ST_RD: begin
        sm_re     = 1'b1;
        sm_raddr  = idx_addr;
        state_nxt = (req_mode_r == MODE_REL) ? ST_REL : ST_CHK;
      end
      ST_REL: begin
        if (idx_known && ent_live && (free_count_r < CNT_W'(SLOTS))) begin
          sm_we          = 1'b1;
          fl_we          = 1'b1;
          free_count_nxt = free_count_r + 1'b1;
          res_ok_nxt     = 1'b1;
          res_slot_nxt   = idx_addr;
          res_gen_nxt    = ent_gen;
        end
        state_nxt = ST_RESP;
      end
      ST_CHK: begin
        if (idx_known && (GC_W'(ent_gen) == GC_W'(req_hgen_r))) begin
          res_ok_nxt   = 1'b1;
          res_slot_nxt = idx_addr;
          res_gen_nxt  = ent_gen;
        end
        state_nxt = ST_RESP;
      end
      ST_SCAN: begin
        if (scan_i_r < free_count_r) begin
          fl_re          = 1'b1;
          scan_ctl.issue = 1'b1;
          scan_i_nxt     = scan_i_r + 1'b1;
        end else if (!scan_sts.busy) begin
          state_nxt = scan_sts.found ? ST_AL_RD : ST_RESP;
        end
      end
      ST_AL_RD: begin
        fl_re     = 1'b1;
        fl_raddr  = IDX_W'(free_count_r - 1'b1);
        state_nxt = ST_AL_MOVE;
      end
      ST_AL_MOVE: begin
        sm_we          = 1'b1;
        sm_waddr       = best_slot;
        sm_wdata       = {req_w_r, req_h_r, GEN_BITS'(best_gen + 1'b1), 1'b1};
        fl_we          = 1'b1;
        fl_waddr       = best_pos;
        fl_wdata       = fl_rdata;
        free_count_nxt = free_count_r - 1'b1;
        res_ok_nxt     = 1'b1;
        res_slot_nxt   = best_slot;
        res_gen_nxt    = GEN_BITS'(best_gen + 1'b1);
        state_nxt      = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid             = out_valid_r;
  assign out_ok                = out_ok_r;
  assign out_result_slot       = out_slot_r;
  assign out_result_generation = out_gen_r;

endmodule
`default_nettype wire
